@@ src/xrd_pkg.sv @@
// Shared types, constants and helper functions for the XYZ to RGB converter.
package xrd_pkg;

	// Powers of ten used for decimal digit counting
	localparam logic [31:0] POW10 [0:9] = '{
		32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
		32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
	};

	// Matrix coefficients, scaled by 10^4
	typedef enum logic [3:0] {
		C_RX, C_RY, C_RZ,
		C_GY, C_GX, C_GZ,
		C_BY, C_BX, C_BZ
	} coef_idx_t;

	// One component as seen by a product term
	typedef struct packed {
		logic [31:0] mag;  // magnitude, -2^31 maps to 2^31
		logic        neg;  // sign of the component
		logic [3:0]  n;    // decimal digit count, 0 for zero
	} xrd_operand_t;

	function automatic logic [14:0] coef_value(coef_idx_t idx);
		logic [14:0] c;
		unique case (idx)
			C_RX: c = 15'd23706;
			C_RY: c = 15'd5138;
			C_RZ: c = 15'd53;
			C_GY: c = 15'd14253;
			C_GX: c = 15'd9000;
			C_GZ: c = 15'd147;
			C_BY: c = 15'd886;
			C_BX: c = 15'd4706;
			C_BZ: c = 15'd10094;
			default: c = 15'd0;
		endcase
		return c;
	endfunction

	// Decimal digit count of a coefficient
	function automatic logic [2:0] coef_digits(coef_idx_t idx);
		logic [2:0] d;
		unique case (idx)
			C_RX, C_GY, C_BZ: d = 3'd5;
			C_RY, C_GX, C_BX: d = 3'd4;
			C_GZ, C_BY:       d = 3'd3;
			C_RZ:             d = 3'd2;
			default:          d = 3'd0;
		endcase
		return d;
	endfunction

	// Reciprocal multipliers for exact unsigned 32-bit division by 10^k
	function automatic logic [31:0] div_magic(logic [2:0] k);
		logic [31:0] m;
		case (k)
			3'd1: m = 32'hCCCC_CCCD;
			3'd2: m = 32'h51EB_851F;
			3'd3: m = 32'h1062_4DD3;
			3'd4: m = 32'hD1B7_1759;
			default: m = 32'd0;
		endcase
		return m;
	endfunction

	function automatic logic [5:0] div_shift(logic [2:0] k);
		logic [5:0] s;
		case (k)
			3'd1: s = 6'd35;
			3'd2: s = 6'd37;
			3'd3: s = 6'd38;
			3'd4: s = 6'd45;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

endpackage

@@ src/xyz_to_rgb_decimal_fixed.sv @@
// Throughput: one XYZ triple per cycle; stalls only when the output is held.
// Six register stages: input/digit count, two reciprocal multiplies for the
// decimal scale-downs, the coefficient product, the tens scaling, the sums.
// Reset (arst_n low, asynchronous) clears all valid bits; data is not reset.
module xyz_to_rgb_decimal_fixed (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // x_value[31:0], y_value[63:32], z_value[95:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // r_value[31:0], g_value[63:32], b_value[95:64]
);

	logic        advance;
	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [31:0] comp [0:2];
	logic [31:0] mag_c [0:2];
	logic [3:0]  n_c [0:2];
	xrd_pkg::xrd_operand_t op_s1 [0:2];
	logic [31:0] t [0:8];
	logic [31:0] r_s6, g_s6, b_s6;

	// Whole pipeline moves together unless the output is held
	assign advance  = !valid_s6 || m_tready;
	assign s_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// Stage 1: magnitudes, signs and digit counts
	assign comp[0] = s_tdata[31:0];
	assign comp[1] = s_tdata[63:32];
	assign comp[2] = s_tdata[95:64];

	for (genvar i = 0; i < 3; i++) begin : g_in
		assign mag_c[i] = comp[i][31] ? (32'd0 - comp[i]) : comp[i];

		xrd_digits u_digits (
			.mag (mag_c[i]),
			.n   (n_c[i])
		);

		always_ff @(posedge clk) begin
			if (advance) begin
				op_s1[i].mag <= mag_c[i];
				op_s1[i].neg <= comp[i][31];
				op_s1[i].n   <= n_c[i];
			end
		end
	end

	// Product terms, stages 2 to 5
	xrd_term #(.IDX(xrd_pkg::C_RX)) u_rx (
		.clk(clk), .en(advance), .op(op_s1[0]), .term(t[0])
	);
	xrd_term #(.IDX(xrd_pkg::C_RY)) u_ry (
		.clk(clk), .en(advance), .op(op_s1[1]), .term(t[1])
	);
	xrd_term #(.IDX(xrd_pkg::C_RZ)) u_rz (
		.clk(clk), .en(advance), .op(op_s1[2]), .term(t[2])
	);
	xrd_term #(.IDX(xrd_pkg::C_GY)) u_gy (
		.clk(clk), .en(advance), .op(op_s1[1]), .term(t[3])
	);
	xrd_term #(.IDX(xrd_pkg::C_GX)) u_gx (
		.clk(clk), .en(advance), .op(op_s1[0]), .term(t[4])
	);
	xrd_term #(.IDX(xrd_pkg::C_GZ)) u_gz (
		.clk(clk), .en(advance), .op(op_s1[2]), .term(t[5])
	);
	xrd_term #(.IDX(xrd_pkg::C_BY)) u_by (
		.clk(clk), .en(advance), .op(op_s1[1]), .term(t[6])
	);
	xrd_term #(.IDX(xrd_pkg::C_BX)) u_bx (
		.clk(clk), .en(advance), .op(op_s1[0]), .term(t[7])
	);
	xrd_term #(.IDX(xrd_pkg::C_BZ)) u_bz (
		.clk(clk), .en(advance), .op(op_s1[2]), .term(t[8])
	);

	// Stage 6: matrix row sums, 32-bit wrap
	always_ff @(posedge clk) begin
		if (advance) begin
			r_s6 <= t[0] - t[1] + t[2];
			g_s6 <= t[3] - t[4] - t[5];
			b_s6 <= t[6] - t[7] + t[8];
		end
	end

	assign m_tvalid = valid_s6;
	assign m_tdata  = {b_s6, g_s6, r_s6};

	// Held output blocks new input
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while output held");

	// Accepted transfer enters stage 1
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted transfer lost");

	// Item in stage 5 reaches the output when the pipe moves
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && advance) |=> m_tvalid)
		else $error("item lost before output");

	// A stall freezes the valid bits of stages 1, 3 and 5
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(valid_s1) && $stable(valid_s3) && $stable(valid_s5)))
		else $error("pipeline moved during stall");

endmodule

@@ src/xrd_digits.sv @@
// Decimal digit counter for a 32-bit magnitude.
module xrd_digits (
	input  logic [31:0] mag,
	output logic [3:0]  n
);

	// Count thresholds 10^i that the magnitude reaches
	always_comb begin
		n = 4'd0;
		for (int i = 0; i < 10; i++) begin
			n = n + 4'(mag >= xrd_pkg::POW10[i]);
		end
	end

endmodule

@@ src/xrd_term.sv @@
// One digit-scaled product of a constant coefficient and a component.
module xrd_term #(
	parameter xrd_pkg::coef_idx_t IDX = xrd_pkg::C_RX
) (
	input  logic                    clk,
	input  logic                    en,
	input  xrd_pkg::xrd_operand_t   op,
	output logic [31:0]             term
);

	// Coefficient and its copies with low digits dropped
	localparam logic [14:0] COEF    = xrd_pkg::coef_value(IDX);
	localparam logic [14:0] COEF_D1 = COEF / 15'd10;
	localparam logic [14:0] COEF_D2 = COEF / 15'd100;
	localparam logic [14:0] COEF_D3 = COEF / 15'd1000;
	localparam logic [2:0]  COEF_N  = xrd_pkg::coef_digits(IDX);

	logic [4:0]  dsum;
	logic [2:0]  e_c;
	logic [2:0]  kv_c;

	logic [31:0] mag_s2;
	logic        neg_s2;
	logic [2:0]  e_s2;
	logic [2:0]  kv_s2;
	logic [63:0] mul1_s2;

	logic [63:0] vsh;
	logic [31:0] vq;
	logic [1:0]  kc;
	logic [14:0] cs;
	logic [46:0] pm_full;
	logic [29:0] pm_s3;
	logic        neg_s3;
	logic [2:0]  e_s3;

	logic [2:0]  kd_c;
	logic [61:0] mul2_s4;
	logic [29:0] pm_s4;
	logic        neg_s4;
	logic [2:0]  e_s4;
	logic [2:0]  kd_s4;

	logic [61:0] psh;
	logic [29:0] qd;
	logic [31:0] ps;
	logic [31:0] term_s5;

	// Digits dropped in total: e, first from the coefficient then the component
	always_comb begin
		dsum = 5'(COEF_N) + 5'(op.n);
		e_c  = (dsum >= 5'd10) ? 3'(dsum - 5'd9) : 3'd0;
		kv_c = {1'b0, e_c[2:1]};
	end

	// Stage 2: reciprocal multiply for the component scale-down
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2  <= op.mag;
			neg_s2  <= op.neg;
			e_s2    <= e_c;
			kv_s2   <= kv_c;
			mul1_s2 <= 64'(op.mag) * 64'(xrd_pkg::div_magic(kv_c));
		end
	end

	// Stage 3: scaled coefficient times scaled component
	always_comb begin
		vsh = mul1_s2 >> xrd_pkg::div_shift(kv_s2);
		vq  = (kv_s2 == 3'd0) ? mag_s2 : vsh[31:0];
		kc  = 2'((4'(e_s2) + 4'd1) >> 1);
		case (kc)
			2'd0:    cs = COEF;
			2'd1:    cs = COEF_D1;
			2'd2:    cs = COEF_D2;
			default: cs = COEF_D3;
		endcase
		pm_full = 47'(cs) * 47'(vq);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pm_s3  <= pm_full[29:0];
			neg_s3 <= neg_s2;
			e_s3   <= e_s2;
		end
	end

	// Stage 4: reciprocal multiply for the product scale-down
	assign kd_c = (e_s3 < 3'd4) ? 3'(3'd4 - e_s3) : 3'd0;

	always_ff @(posedge clk) begin
		if (en) begin
			mul2_s4 <= 62'(pm_s3) * 62'(xrd_pkg::div_magic(kd_c));
			pm_s4   <= pm_s3;
			neg_s4  <= neg_s3;
			e_s4    <= e_s3;
			kd_s4   <= kd_c;
		end
	end

	// Stage 5: finish division, apply sign, scale up by tens with wrap
	always_comb begin
		psh = mul2_s4 >> xrd_pkg::div_shift(kd_s4);
		qd  = (kd_s4 == 3'd0) ? pm_s4 : psh[29:0];
		ps  = neg_s4 ? (32'd0 - 32'(qd)) : 32'(qd);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (e_s4)
				3'd5:    term_s5 <= (ps << 3) + (ps << 1);
				3'd6:    term_s5 <= (ps << 6) + (ps << 5) + (ps << 2);
				default: term_s5 <= ps;
			endcase
		end
	end

	assign term = term_s5;

endmodule

@@ tb/xyz_to_rgb_decimal_fixed_tb.sv @@
// Self-checking testbench for the decimal fixed-point XYZ to RGB converter.
`timescale 1ns / 100ps

module xyz_to_rgb_decimal_fixed_tb;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        has_rgb;
		logic [31:0] r;
		logic [31:0] g;
		logic [31:0] b;
	} pixel_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;   // x_value[31:0], y_value[63:32], z_value[95:64]
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;   // r_value[31:0], g_value[63:32], b_value[95:64]

	logic [95:0] rgb_pending [$];
	pixel_row_t  pixel_rows [$];
	pixel_row_t  check_rows [$];
	int          fail_count;
	int          cycle_count;
	bit          hold_sink;

	localparam int N_RANDOM    = 900;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LATENCY     = 6;

	xyz_to_rgb_decimal_fixed dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Decimal digits minus one; zero gives -1
	function automatic int digit_order(int signed v);
		int n;
		n = -1;
		while (v != 0) begin
			v = v / 10;
			n++;
		end
		return n;
	endfunction

	// Digit-scaled product of a coefficient and a component, 32-bit wrap
	function automatic logic [31:0] term(int signed coef, logic [31:0] comp);
		int signed      c;
		int signed      v;
		int             dc;
		int             dv;
		int             frac;
		longint signed  wide;
		int signed      p;
		logic [31:0]    w;
		c = coef;
		v = comp;
		dc = digit_order(c);
		dv = digit_order(v);
		frac = 8;
		while (dc + dv >= 8) begin
			c = c / 10;
			dc--;
			frac--;
			if (dc + dv >= 8) begin
				v = v / 10;
				dv--;
				frac--;
			end
		end
		wide = longint'(c) * longint'(v);
		p = int'(wide[31:0]);
		if (frac > 4) begin
			while (frac > 4) begin
				p = p / 10;
				frac--;
			end
			return p;
		end
		w = p;
		while (frac < 4) begin
			w = w * 32'd10;
			frac++;
		end
		return w;
	endfunction

	function automatic logic [95:0] xyz_to_rgb(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		logic [31:0] r;
		logic [31:0] g;
		logic [31:0] b;
		r = term(23706, x) - term(5138, y) + term(53, z);
		g = term(14253, y) - term(9000, x) - term(147, z);
		b = term(886, y) - term(4706, x) + term(10094, z);
		return {b, g, r};
	endfunction

	function automatic logic [31:0] rand_component();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 20000);
			2: return -$urandom_range(0, 20000);
			3: return $urandom_range(0, 99999999);
			4: return 32'(10 ** $urandom_range(0, 9)) - $urandom_range(0, 1);
			default: return {$urandom_range(0, 1) ? 24'hFF_FFFF : 24'h0, 8'h0}
				^ 32'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic add_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic has_rgb, logic [31:0] r, logic [31:0] g, logic [31:0] b);
		pixel_row_t row;
		row.x = x; row.y = y; row.z = z;
		row.has_rgb = has_rgb; row.r = r; row.g = g; row.b = b;
		pixel_rows.push_back(row);
		check_rows.push_back(row);
	endtask

	task automatic send_pixel(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int gap;
		gap = $urandom_range(0, 15);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {z, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Expected result is queued when the input transfer is accepted
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			if (check_rows.size() != 0 && check_rows[0].has_rgb
					&& check_rows[0].x == s_tdata[31:0]) begin
				rgb_pending.push_back({check_rows[0].b, check_rows[0].g, check_rows[0].r});
			end else begin
				rgb_pending.push_back(xyz_to_rgb(s_tdata[31:0], s_tdata[63:32],
					s_tdata[95:64]));
			end
			if (check_rows.size() != 0)
				void'(check_rows.pop_front());
		end
	end

	// Output check, one transfer at a time
	always @(posedge clk) begin
		logic [95:0] exp_rgb;
		if (arst_n && m_tvalid && m_tready) begin
			if (rgb_pending.size() == 0) begin
				$display("%0t: unexpected transfer %h", $time, m_tdata);
				fail_count++;
			end else begin
				exp_rgb = rgb_pending.pop_front();
				if (exp_rgb[31:0] != m_tdata[31:0]) begin
					$display("%0t: r_value expected %h actual %h", $time,
						exp_rgb[31:0], m_tdata[31:0]);
					fail_count++;
				end
				if (exp_rgb[63:32] != m_tdata[63:32]) begin
					$display("%0t: g_value expected %h actual %h", $time,
						exp_rgb[63:32], m_tdata[63:32]);
					fail_count++;
				end
				if (exp_rgb[95:64] != m_tdata[95:64]) begin
					$display("%0t: b_value expected %h actual %h", $time,
						exp_rgb[95:64], m_tdata[95:64]);
					fail_count++;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off
	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n);
		while (1) begin
			if (hold_sink) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_sink = 1'b0;
			end
			stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	// Timeout watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Stimulus
	initial begin
		pixel_row_t row;
		fail_count = 0;
		hold_sink = 1'b0;
		arst_n   = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero and unit values read off directly, extremes predicted
		add_row(32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0, 32'd0);
		add_row(32'd10000, 32'd0, 32'd0, 1'b1, 32'd23700, -32'sd9000, -32'sd4706);
		add_row(32'd0, 32'd10000, 32'd0, 1'b1, -32'sd5138, 32'd14250, 32'd886);
		add_row(32'd0, 32'd0, 32'd10000, 1'b1, 32'd53, -32'sd147, 32'd10090);
		add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 0, 0, 0);
		add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 0, 0, 0);
		add_row(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b0, 0, 0, 0);
		add_row(32'd9999, 32'd99999, 32'd999999, 1'b0, 0, 0, 0);
		add_row(32'd1000, 32'd10000000, 32'd100000000, 1'b0, 0, 0, 0);
		add_row(32'd1000000000, 32'd999999999, 32'hC465_3600, 1'b0, 0, 0, 0);
		add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1'b0, 0, 0, 0);
		add_row(-32'sd10000, -32'sd10000, -32'sd10000, 1'b0, 0, 0, 0);
		foreach (pixel_rows[i]) begin
			row = pixel_rows[i];
			send_pixel(row.x, row.y, row.z);
		end

		// back-to-back burst while the receiver holds off
		hold_sink = 1'b1;
		for (int i = 0; i < 40; i++) begin
			s_tvalid <= 1'b1;
			s_tdata  <= {rand_component(), rand_component(), rand_component()};
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
		end

		for (int i = 0; i < N_RANDOM; i++)
			send_pixel(rand_component(), rand_component(), rand_component());
		s_tvalid <= 1'b0;

		while (rgb_pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY * 4) @(posedge clk);
		if (rgb_pending.size() != 0) begin
			$display("%0t: expected %0d more transfers, actual 0", $time,
				rgb_pending.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
src/xrd_pkg.sv
src/xrd_digits.sv
src/xrd_term.sv
src/xyz_to_rgb_decimal_fixed.sv
tb/xyz_to_rgb_decimal_fixed_tb.sv
